// ----- rtl/py2r_pkg.sv -----
// types, constants and helpers shared by the packed yuv 4:2:2 to rgb888 converter
package py2r_pkg;

    typedef logic [7:0]        pix_byte_t;
    typedef logic [2:0]        order_t;
    typedef logic signed [8:0] chroma_t;
    typedef logic signed [17:0] acc_t;

    localparam order_t ORDER_YUYV = 3'd0;
    localparam order_t ORDER_YVYU = 3'd1;
    localparam order_t ORDER_UYVY = 3'd2;
    localparam order_t ORDER_VYUY = 3'd3;

    localparam chroma_t CHROMA_MID = 9'sd128;

    localparam acc_t CR_TO_R = 18'sd359;
    localparam acc_t CB_TO_G = 18'sd88;
    localparam acc_t CR_TO_G = 18'sd183;
    localparam acc_t CB_TO_B = 18'sd454;

    localparam pix_byte_t CHAN_MAX = 8'd255;

    typedef struct packed {
        pix_byte_t luma_0;
        pix_byte_t luma_1;
        chroma_t   cb;
        chroma_t   cr;
    } py2r_entry_t;

    function automatic chroma_t center_chroma(pix_byte_t b);
        return chroma_t'({1'b0, b}) - CHROMA_MID;
    endfunction

    // arithmetic shift right by 8, then clamp to 0..255
    function automatic pix_byte_t clamp_channel(acc_t a);
        pix_byte_t res;
        if (a[17])
        begin
            res = '0;
        end
        else if (a[16])
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = a[15:8];
        end
        return res;
    endfunction

endpackage

// ----- rtl/py2r_if.sv -----
// channel interfaces: macropixel input, pixel output and byte order write
interface py2r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;

    modport source (output valid, output byte_0, output byte_1, output byte_2,
                    output byte_3, input ready);
    modport sink (input valid, input byte_0, input byte_1, input byte_2,
                  input byte_3, output ready);
endinterface

interface py2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pair_last;

    modport source (output valid, output red, output green, output blue,
                    output pair_last, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input pair_last, output ready);
endinterface

interface py2r_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_order;

    modport source (output valid, output byte_order, input ready);
    modport sink (input valid, input byte_order, output ready);
endinterface

// ----- rtl/packed_yuv422_to_rgb888.sv -----
// top level of the packed yuv 4:2:2 to rgb888 converter
//
// channels: macropixel takes one beat of four bytes holding two luma samples
// and one shared chroma pair; pixel gives two rgb888 beats per macropixel,
// pair_last low on the first and high on the second; cfg writes the 3-bit
// byte order (yuyv, yvyu, uyvy, vyuy; any other code gives black pixels).
// cfg is always ready; it must be written only while no macropixel is in
// flight, which the block itself does not enforce.
// the front end unpacks a macropixel into a small queue; the back end takes
// one pixel per cycle from the queue head, while pixel.ready does not stall
// it, through a product register stage and a clamped output register.
// each pixel passes the queue, the product register and the output register
// in that order, the second pixel of a macropixel following the first.
// when pixel.ready is low the output register holds its beat, the back end
// stops once its product register is full, and macropixel beats are still
// taken until the queue is full.
// reset clears the queue, the pipeline valids and sets the order to yuyv.
module packed_yuv422_to_rgb888 import py2r_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    py2r_in_if.sink     macropixel,
    py2r_cfg_if.sink    cfg,
    py2r_out_if.source  pixel
);

    logic        push;
    logic        pop;
    logic        full;
    logic        not_empty;
    py2r_entry_t push_entry;
    py2r_entry_t head;

    py2r_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .macropixel (macropixel),
        .cfg        (cfg),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    py2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    py2r_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (not_empty),
        .entry       (head),
        .pop         (pop),
        .pixel       (pixel)
    );

endmodule

// ----- rtl/py2r_front.sv -----
// front end: byte order register and unpacking of one macropixel into luma and chroma
module py2r_front import py2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    py2r_in_if.sink     macropixel,
    py2r_cfg_if.sink    cfg,
    input  logic        full,
    output logic        push,
    output py2r_entry_t push_entry
);

    order_t byte_order_reg;
    order_t byte_order_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        byte_order_next = byte_order_reg;
        if (cfg.valid)
        begin
            byte_order_next = cfg.byte_order;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_reg <= ORDER_YUYV;
        end
        else
        begin
            byte_order_reg <= byte_order_next;
        end
    end

    assign macropixel.ready = !full;
    assign push             = macropixel.valid && !full;

    always_comb
    begin
        push_entry = '0;
        case (byte_order_reg)
            ORDER_YUYV:
            begin
                push_entry.luma_0 = macropixel.byte_0;
                push_entry.luma_1 = macropixel.byte_2;
                push_entry.cb     = center_chroma(macropixel.byte_1);
                push_entry.cr     = center_chroma(macropixel.byte_3);
            end
            ORDER_YVYU:
            begin
                push_entry.luma_0 = macropixel.byte_0;
                push_entry.luma_1 = macropixel.byte_2;
                push_entry.cr     = center_chroma(macropixel.byte_1);
                push_entry.cb     = center_chroma(macropixel.byte_3);
            end
            ORDER_UYVY:
            begin
                push_entry.luma_0 = macropixel.byte_1;
                push_entry.luma_1 = macropixel.byte_3;
                push_entry.cb     = center_chroma(macropixel.byte_0);
                push_entry.cr     = center_chroma(macropixel.byte_2);
            end
            ORDER_VYUY:
            begin
                push_entry.luma_0 = macropixel.byte_1;
                push_entry.luma_1 = macropixel.byte_3;
                push_entry.cr     = center_chroma(macropixel.byte_0);
                push_entry.cb     = center_chroma(macropixel.byte_2);
            end
            default:
            begin
                push_entry = '0;
            end
        endcase
    end

endmodule

// ----- rtl/py2r_queue.sv -----
// small register queue between front and back end
module py2r_queue import py2r_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  py2r_entry_t push_entry,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output py2r_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    py2r_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("queue count above depth");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");
`endif

endmodule

// ----- rtl/py2r_back.sv -----
// back end: two pixels per entry through a product stage and a clamp stage
module py2r_back import py2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_valid,
    input  py2r_entry_t entry,
    output logic        pop,
    py2r_out_if.source  pixel
);

    logic      phase_reg;
    logic      phase_next;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      out_valid_reg;
    logic      out_valid_next;

    acc_t      ys_reg;
    acc_t      ys_next;
    acc_t      p_r_reg;
    acc_t      p_r_next;
    acc_t      p_gcb_reg;
    acc_t      p_gcb_next;
    acc_t      p_gcr_reg;
    acc_t      p_gcr_next;
    acc_t      p_b_reg;
    acc_t      p_b_next;
    logic      s1_last_reg;

    pix_byte_t red_reg;
    pix_byte_t red_next;
    pix_byte_t green_reg;
    pix_byte_t green_next;
    pix_byte_t blue_reg;
    pix_byte_t blue_next;
    logic      last_reg;

    logic      out_adv;
    logic      s1_adv;
    logic      issue;
    pix_byte_t luma;

    assign out_adv = !out_valid_reg || pixel.ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign issue   = entry_valid && s1_adv;
    assign pop     = issue && phase_reg;

    always_comb
    begin
        phase_next     = issue ? !phase_reg : phase_reg;
        s1_valid_next  = s1_adv ? issue : s1_valid_reg;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // product stage
    always_comb
    begin
        luma       = phase_reg ? entry.luma_1 : entry.luma_0;
        ys_next    = acc_t'({luma, 8'd0});
        p_r_next   = acc_t'(entry.cr) * CR_TO_R;
        p_gcb_next = acc_t'(entry.cb) * CB_TO_G;
        p_gcr_next = acc_t'(entry.cr) * CR_TO_G;
        p_b_next   = acc_t'(entry.cb) * CB_TO_B;
    end

    // sum and clamp stage
    always_comb
    begin
        red_next   = clamp_channel(ys_reg + p_r_reg);
        green_next = clamp_channel(ys_reg - p_gcb_reg - p_gcr_reg);
        blue_next  = clamp_channel(ys_reg + p_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            ys_reg      <= ys_next;
            p_r_reg     <= p_r_next;
            p_gcb_reg   <= p_gcb_next;
            p_gcr_reg   <= p_gcr_next;
            p_b_reg     <= p_b_next;
            s1_last_reg <= phase_reg;
        end
        if (out_adv && s1_valid_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last_reg  <= s1_last_reg;
        end
    end

    assign pixel.valid     = out_valid_reg;
    assign pixel.red       = red_reg;
    assign pixel.green     = green_reg;
    assign pixel.blue      = blue_reg;
    assign pixel.pair_last = last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg && $stable(ys_reg) && $stable(p_r_reg))
        else $error("product stage lost while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel.ready) |=> $stable(red_reg) && $stable(last_reg))
        else $error("output pixel changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> entry_valid)
        else $error("second pixel pending without queue entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_last_reg == $past(phase_reg))
        else $error("pair position not carried with pixel");
`endif

endmodule

// ----- tb/py2r_pixel_checker.sv -----
// pixel checker: predicts the two rgb888 pixels of each macropixel and compares them
`timescale 1ns / 100ps

module py2r_pixel_checker import py2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  pix_byte_t byte_0,
    input  pix_byte_t byte_1,
    input  pix_byte_t byte_2,
    input  pix_byte_t byte_3,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  order_t    cfg_order,
    input  logic      out_valid,
    input  logic      out_ready,
    input  pix_byte_t red,
    input  pix_byte_t green,
    input  pix_byte_t blue,
    input  logic      pair_last,
    output int        fail_count,
    output int        pending_pixels
);

    localparam int CHROMA_CENTER = 128;
    localparam int K_CR_R = 359;
    localparam int K_CB_G = 88;
    localparam int K_CR_G = 183;
    localparam int K_CB_B = 454;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        pix_byte_t red;
        pix_byte_t green;
        pix_byte_t blue;
        logic      last;
    } rgb_pixel_t;

    rgb_pixel_t pixel_q[$];
    order_t     order_reg;
    int         mismatches;

    function automatic pix_byte_t saturate(input int acc);
        int q;
        q = acc >>> 8;
        if (q < 0)
        begin
            return 8'd0;
        end
        if (q > 255)
        begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic rgb_pixel_t convert_pixel(input int luma, input int cb, input int cr,
                                                 input logic last);
        rgb_pixel_t px;
        int         ys;
        ys = luma * 256;
        px.red   = saturate(ys + K_CR_R * cr);
        px.green = saturate(ys - K_CB_G * cb - K_CR_G * cr);
        px.blue  = saturate(ys + K_CB_B * cb);
        px.last  = last;
        return px;
    endfunction

    task automatic predict_macropixel(input pix_byte_t b0, input pix_byte_t b1,
                                      input pix_byte_t b2, input pix_byte_t b3);
        int y0;
        int y1;
        int cb;
        int cr;
        y0 = 0;
        y1 = 0;
        cb = 0;
        cr = 0;
        case (order_reg)
            ORDER_YUYV:
            begin
                y0 = int'(b0);
                y1 = int'(b2);
                cb = int'(b1) - CHROMA_CENTER;
                cr = int'(b3) - CHROMA_CENTER;
            end
            ORDER_YVYU:
            begin
                y0 = int'(b0);
                y1 = int'(b2);
                cr = int'(b1) - CHROMA_CENTER;
                cb = int'(b3) - CHROMA_CENTER;
            end
            ORDER_UYVY:
            begin
                y0 = int'(b1);
                y1 = int'(b3);
                cb = int'(b0) - CHROMA_CENTER;
                cr = int'(b2) - CHROMA_CENTER;
            end
            ORDER_VYUY:
            begin
                y0 = int'(b1);
                y1 = int'(b3);
                cr = int'(b0) - CHROMA_CENTER;
                cb = int'(b2) - CHROMA_CENTER;
            end
            default:
            begin
            end
        endcase
        pixel_q.push_back(convert_pixel(y0, cb, cr, 1'b0));
        pixel_q.push_back(convert_pixel(y1, cb, cr, 1'b1));
    endtask

    task automatic note_mismatch(input string what, input rgb_pixel_t exp_px,
                                 input rgb_pixel_t got_px);
        if (mismatches < MAX_REPORTS)
        begin
            $display("%t pixel %s: expected r=%0d g=%0d b=%0d last=%0b,",
                     $realtime, what, exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                     " got r=%0d g=%0d b=%0d last=%0b",
                     got_px.red, got_px.green, got_px.blue, got_px.last);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgb_pixel_t got_px;
        rgb_pixel_t exp_px;
        if (!rst_n)
        begin
            order_reg = ORDER_YUYV;
            pixel_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_pixels <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                order_reg = cfg_order;
            end
            if (in_valid && in_ready)
            begin
                predict_macropixel(byte_0, byte_1, byte_2, byte_3);
            end
            if (out_valid && out_ready)
            begin
                got_px = {red, green, blue, pair_last};
                if (pixel_q.size() == 0)
                begin
                    note_mismatch("beat with none expected", '0, got_px);
                end
                else
                begin
                    exp_px = pixel_q.pop_front();
                    if (got_px.red !== exp_px.red || got_px.green !== exp_px.green ||
                        got_px.blue !== exp_px.blue || got_px.last !== exp_px.last)
                    begin
                        note_mismatch("mismatch", exp_px, got_px);
                    end
                end
            end
            fail_count <= mismatches;
            pending_pixels <= pixel_q.size();
        end
    end

endmodule

// ----- tb/tb_packed_yuv422_to_rgb888.sv -----
// top of the packed yuv 4:2:2 to rgb888 testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_packed_yuv422_to_rgb888;
    import py2r_pkg::*;

    localparam order_t ORDER_NONE_LO = 3'd4;
    localparam order_t ORDER_NONE_HI = 3'd7;
    localparam int IDLE_PCT = 11;
    localparam int PHASES = 12;
    localparam int PHASE_BEATS = 100;
    localparam int CALM_PHASE = 3;
    localparam int DRAIN_PHASE = 6;
    localparam int TAIL_CYCLES = 8;

    localparam order_t DIRECTED_ORDERS [6] = '{ORDER_YUYV, ORDER_YVYU, ORDER_UYVY,
                                                ORDER_VYUY, ORDER_NONE_LO, ORDER_NONE_HI};
    localparam logic [31:0] DIRECTED_WORDS [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                   32'hFF00_FF00, 32'h00FF_00FF};

    logic clk;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   pending_pixels;

    py2r_in_if  mp_if ();
    py2r_cfg_if cfg_if ();
    py2r_out_if px_if ();

    packed_yuv422_to_rgb888 u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .macropixel (mp_if),
        .cfg        (cfg_if),
        .pixel      (px_if)
    );

    py2r_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (mp_if.valid),
        .in_ready       (mp_if.ready),
        .byte_0         (mp_if.byte_0),
        .byte_1         (mp_if.byte_1),
        .byte_2         (mp_if.byte_2),
        .byte_3         (mp_if.byte_3),
        .cfg_valid      (cfg_if.valid),
        .cfg_ready      (cfg_if.ready),
        .cfg_order      (cfg_if.byte_order),
        .out_valid      (px_if.valid),
        .out_ready      (px_if.ready),
        .red            (px_if.red),
        .green          (px_if.green),
        .blue           (px_if.blue),
        .pair_last      (px_if.pair_last),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // pixel sink stalls at random, except in the calm phase
    always @(posedge clk)
    begin
        px_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        for (int i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                w[i*8 +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
            else
            begin
                w[i*8 +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return w;
    endfunction

    function automatic order_t random_order();
        if ($urandom_range(0, 4) == 0)
        begin
            return order_t'($urandom_range(ORDER_NONE_LO, ORDER_NONE_HI));
        end
        return order_t'($urandom_range(ORDER_YUYV, ORDER_VYUY));
    endfunction

    task automatic send_macropixel(input logic [31:0] word);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            mp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        mp_if.valid  <= 1'b1;
        mp_if.byte_0 <= word[31:24];
        mp_if.byte_1 <= word[23:16];
        mp_if.byte_2 <= word[15:8];
        mp_if.byte_3 <= word[7:0];
        @(posedge clk);
        while (!mp_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        mp_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_pixels != 0);
    endtask

    task automatic write_order(input order_t ord);
        wait_drained();
        cfg_if.valid      <= 1'b1;
        cfg_if.byte_order <= ord;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        mp_if.valid       <= 1'b0;
        mp_if.byte_0      <= 8'd0;
        mp_if.byte_1      <= 8'd0;
        mp_if.byte_2      <= 8'd0;
        mp_if.byte_3      <= 8'd0;
        cfg_if.valid      <= 1'b0;
        cfg_if.byte_order <= ORDER_YUYV;
        calm              <= 1'b0;
        rst_n             <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every byte order, then the black codes, on field extremes
        foreach (DIRECTED_ORDERS[i])
        begin
            write_order(DIRECTED_ORDERS[i]);
            foreach (DIRECTED_WORDS[j])
            begin
                send_macropixel(DIRECTED_WORDS[j]);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_order(random_order());
            calm <= (p == CALM_PHASE);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                send_macropixel(random_word());
                if (p == DRAIN_PHASE && n == PHASE_BEATS / 2)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/py2r_pkg.sv
rtl/py2r_if.sv
rtl/py2r_front.sv
rtl/py2r_queue.sv
rtl/py2r_back.sv
rtl/packed_yuv422_to_rgb888.sv
tb/py2r_pixel_checker.sv
tb/tb_packed_yuv422_to_rgb888.sv
